/* rtl/core/khf_pkg.sv */
// shared types, constants and helpers of the keyed class hysteresis filter
`default_nettype none

package khf_pkg;

  localparam int KEY_W       = 6;
  localparam int CLASS_W     = 4;
  localparam int GROUP_W     = 2;
  localparam int REP_W       = 8;
  localparam int CONF_W      = 16;
  localparam int MIN_DWELL_W = 16;
  localparam int DWELL_OUT_W = 16;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam int NUM_KEYS_DEF    = 64;
  localparam int DWELL_WIDTH_DEF = 16;

  localparam logic [CLASS_W-1:0]     CLASS_UNDEF  = 4'd0;
  localparam logic [CLASS_W-1:0]     MAX_CLASS    = 4'd12;
  localparam logic [REP_W-1:0]       REP_MAX      = 8'd255;
  localparam logic [MIN_DWELL_W-1:0] CP_MIN_DWELL = 16'd5;

  localparam logic [GROUP_W-1:0] GRP_TRENDING = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_RANGING  = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_VOLATILE = 2'd2;
  localparam logic [GROUP_W-1:0] GRP_UNCLEAR  = 2'd3;

  localparam logic [1:0] REG_CONFIRM_REPEATS = 2'd0;
  localparam logic [1:0] REG_MIN_DWELL       = 2'd1;
  localparam logic [1:0] REG_MIN_SWITCH_CONF = 2'd2;

  localparam logic [REP_W-1:0]       RST_CONFIRM_REPEATS = 8'd3;
  localparam logic [MIN_DWELL_W-1:0] RST_MIN_DWELL       = 16'd5;
  localparam logic [CONF_W-1:0]      RST_MIN_SWITCH_CONF = 16'd19661;

  typedef struct packed {
    logic [REP_W-1:0]       confirm_repeats;
    logic [MIN_DWELL_W-1:0] min_dwell;
    logic [CONF_W-1:0]      min_switch_confidence;
  } cfg_t;

  typedef struct packed {
    logic [CLASS_W-1:0]     filtered_class;
    logic [GROUP_W-1:0]     class_group;
    logic                   overrode;
    logic [REP_W-1:0]       repeats_remaining;
    logic [DWELL_OUT_W-1:0] dwell_count;
    logic                   transition;
    logic [CLASS_W-1:0]     previous_class;
  } result_t;

  function automatic logic [GROUP_W-1:0] group_of(input logic [CLASS_W-1:0] cls);
    logic [GROUP_W-1:0] grp;
    unique case (cls)
      4'd1, 4'd2, 4'd3, 4'd4:           grp = GRP_TRENDING;
      4'd5, 4'd7, 4'd12:                grp = GRP_RANGING;
      4'd6, 4'd8, 4'd9, 4'd10, 4'd11:   grp = GRP_VOLATILE;
      default:                          grp = GRP_UNCLEAR;
    endcase
    return grp;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/khf_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module khf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/khf_regs.sv */
// apb configuration registers of the keyed class hysteresis filter
`default_nettype none

module khf_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [khf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [khf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [khf_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output khf_pkg::cfg_t                     cfg_o
);

  khf_pkg::cfg_t cfg_q;
  khf_pkg::cfg_t cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[khf_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        khf_pkg::REG_CONFIRM_REPEATS: cfg_d.confirm_repeats = pwdata[khf_pkg::REP_W-1:0];
        khf_pkg::REG_MIN_DWELL:       cfg_d.min_dwell = pwdata[khf_pkg::MIN_DWELL_W-1:0];
        khf_pkg::REG_MIN_SWITCH_CONF: begin
          cfg_d.min_switch_confidence = pwdata[khf_pkg::CONF_W-1:0];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      khf_pkg::REG_CONFIRM_REPEATS: prdata = khf_pkg::PDATA_W'(cfg_q.confirm_repeats);
      khf_pkg::REG_MIN_DWELL:       prdata = khf_pkg::PDATA_W'(cfg_q.min_dwell);
      khf_pkg::REG_MIN_SWITCH_CONF: prdata = khf_pkg::PDATA_W'(cfg_q.min_switch_confidence);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_repeats       <= khf_pkg::RST_CONFIRM_REPEATS;
      cfg_q.min_dwell             <= khf_pkg::RST_MIN_DWELL;
      cfg_q.min_switch_confidence <= khf_pkg::RST_MIN_SWITCH_CONF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/khf_update.sv */
// per-key state update and result formation of the hysteresis filter
`default_nettype none

module khf_update #(
  parameter int DWELL_WIDTH = khf_pkg::DWELL_WIDTH_DEF
) (
  input  wire khf_pkg::cfg_t                  cfg_i,
  input  wire logic [khf_pkg::CLASS_W-1:0]    conf_i,
  input  wire logic [khf_pkg::CLASS_W-1:0]    cand_i,
  input  wire logic [khf_pkg::REP_W-1:0]      reps_i,
  input  wire logic [DWELL_WIDTH-1:0]         dwell_i,
  input  wire logic [khf_pkg::CLASS_W-1:0]    raw_class_i,
  input  wire logic [khf_pkg::CONF_W-1:0]     confidence_i,
  input  wire logic                           change_point_i,
  output logic      [khf_pkg::CLASS_W-1:0]    conf_o,
  output logic      [khf_pkg::CLASS_W-1:0]    cand_o,
  output logic      [khf_pkg::REP_W-1:0]      reps_o,
  output logic      [DWELL_WIDTH-1:0]         dwell_o,
  output khf_pkg::result_t                    res_o
);

  logic [khf_pkg::CLASS_W-1:0]     raw;
  logic [khf_pkg::REP_W-1:0]       need_reps;
  logic [khf_pkg::MIN_DWELL_W-1:0] need_dwell;
  logic                            dwell_ok;
  logic [khf_pkg::REP_W-1:0]       reps_inc;
  logic [31:0]                     dwell_ext;

  always_comb begin
    raw = (raw_class_i > khf_pkg::MAX_CLASS) ? khf_pkg::CLASS_UNDEF : raw_class_i;

    if (change_point_i) begin
      need_reps = (cfg_i.confirm_repeats > 8'd1) ? cfg_i.confirm_repeats - 8'd1 : 8'd1;
      need_dwell = (cfg_i.min_dwell > khf_pkg::CP_MIN_DWELL) ? cfg_i.min_dwell
                                                            : khf_pkg::CP_MIN_DWELL;
    end else begin
      need_reps  = cfg_i.confirm_repeats;
      need_dwell = cfg_i.min_dwell;
    end

    dwell_ok = 32'(dwell_i) >= 32'(need_dwell);
    reps_inc = (reps_i == khf_pkg::REP_MAX) ? reps_i : reps_i + 8'd1;

    conf_o  = conf_i;
    cand_o  = cand_i;
    reps_o  = reps_i;
    dwell_o = dwell_i;

    priority if (conf_i == khf_pkg::CLASS_UNDEF) begin
      conf_o  = raw;
      cand_o  = khf_pkg::CLASS_UNDEF;
      reps_o  = '0;
      dwell_o = DWELL_WIDTH'(1);
    end else if (raw == conf_i) begin
      cand_o = khf_pkg::CLASS_UNDEF;
      reps_o = '0;
      if (dwell_i != '1) begin
        dwell_o = dwell_i + DWELL_WIDTH'(1);
      end
    end else if (raw != cand_i) begin
      cand_o = raw;
      reps_o = 8'd1;
    end else begin
      reps_o = reps_inc;
      if (reps_inc >= need_reps && confidence_i >= cfg_i.min_switch_confidence
          && dwell_ok) begin
        conf_o  = cand_i;
        cand_o  = khf_pkg::CLASS_UNDEF;
        reps_o  = '0;
        dwell_o = DWELL_WIDTH'(1);
      end
    end

    dwell_ext = 32'(dwell_o);

    res_o.filtered_class    = conf_o;
    res_o.class_group       = khf_pkg::group_of(conf_o);
    res_o.overrode          = conf_o != raw;
    res_o.repeats_remaining = (need_reps > reps_o) ? need_reps - reps_o : '0;
    res_o.dwell_count       = dwell_ext[khf_pkg::DWELL_OUT_W-1:0];
    res_o.transition        = (conf_i != conf_o) && (conf_i != khf_pkg::CLASS_UNDEF);
    res_o.previous_class    = conf_i;
  end

endmodule

`default_nettype wire

/* rtl/core/keyed_class_hysteresis_filter.sv */
// top level of the keyed class hysteresis filter: per-key state in one ram
//
//   channel | direction | handshake                 | beat contents
//   cfg     | in/out    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//   in      | in        | in_valid_i / in_stall_o   | key, raw class, confidence, cp
//   out     | out       | out_valid_o / out_stall_i | filtered class and status
//
// one beat per cycle sustained unless the output stalls or the ram is being cleared; each input beat
// passes a ram read at the input edge, then update and write-back into the output register
// back-to-back beats on the same key are served from a one-entry write bypass
// after reset the ram is cleared one entry after another, in_stall_o stays high meanwhile
// a stalled output holds the update stage, which in turn stalls the input
`default_nettype none

module keyed_class_hysteresis_filter #(
  parameter int NUM_KEYS    = khf_pkg::NUM_KEYS_DEF,
  parameter int DWELL_WIDTH = khf_pkg::DWELL_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [khf_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [khf_pkg::PDATA_W-1:0]      pwdata,
  output logic      [khf_pkg::PDATA_W-1:0]      prdata,
  output logic                                  pready,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [khf_pkg::KEY_W-1:0]        key_index_i,
  input  wire logic [khf_pkg::CLASS_W-1:0]      raw_class_i,
  input  wire logic [khf_pkg::CONF_W-1:0]       confidence_i,
  input  wire logic                             change_point_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [khf_pkg::CLASS_W-1:0]      filtered_class_o,
  output logic      [khf_pkg::GROUP_W-1:0]      class_group_o,
  output logic                                  overrode_o,
  output logic      [khf_pkg::REP_W-1:0]        repeats_remaining_o,
  output logic      [khf_pkg::DWELL_OUT_W-1:0]  dwell_count_o,
  output logic                                  transition_o,
  output logic      [khf_pkg::CLASS_W-1:0]      previous_class_o
);

  localparam int AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ENTRY_W = 2 * khf_pkg::CLASS_W + khf_pkg::REP_W + DWELL_WIDTH;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_KEYS - 1);

  khf_pkg::cfg_t cfg;

  khf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // clearing sweep
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // handshake
  logic          in_acc;
  logic          s1_valid_q;
  logic          s1_adv;
  logic          out_valid_q;
  logic          wr_item;
  logic [31:0]   key_ext;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_q || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign key_ext    = 32'(key_index_i);

  // update stage payload
  logic [AW-1:0]                  s1_addr_q;
  logic                           s1_inr_q;
  logic [khf_pkg::CLASS_W-1:0]    s1_raw_q;
  logic [khf_pkg::CONF_W-1:0]     s1_conf_q;
  logic                           s1_cp_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= key_ext[AW-1:0];
      s1_inr_q  <= key_ext < 32'(NUM_KEYS);
      s1_raw_q  <= raw_class_i;
      s1_conf_q <= confidence_i;
      s1_cp_q   <= change_point_i;
    end
  end

  // state ram
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] new_entry;

  assign wr_item   = s1_valid_q && s1_adv && s1_inr_q;
  assign ram_we    = clr_q || wr_item;
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? '0 : new_entry;

  khf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (key_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // write bypass for a read that met a write to the same entry
  logic               byp_valid_q;
  logic [AW-1:0]      byp_addr_q;
  logic [ENTRY_W-1:0] byp_data_q;
  logic               byp_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (wr_item) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_item) begin
      byp_addr_q <= s1_addr_q;
      byp_data_q <= new_entry;
    end
  end

  assign byp_hit = byp_valid_q && (byp_addr_q == s1_addr_q);

  logic [ENTRY_W-1:0]              cur_entry;
  logic [khf_pkg::CLASS_W-1:0]     cur_conf;
  logic [khf_pkg::CLASS_W-1:0]     cur_cand;
  logic [khf_pkg::REP_W-1:0]       cur_reps;
  logic [DWELL_WIDTH-1:0]          cur_dwell;
  logic [khf_pkg::CLASS_W-1:0]     nxt_conf;
  logic [khf_pkg::CLASS_W-1:0]     nxt_cand;
  logic [khf_pkg::REP_W-1:0]       nxt_reps;
  logic [DWELL_WIDTH-1:0]          nxt_dwell;
  khf_pkg::result_t                res;

  assign cur_entry = !s1_inr_q ? '0 : (byp_hit ? byp_data_q : ram_rdata);
  assign {cur_conf, cur_cand, cur_reps, cur_dwell} = cur_entry;
  assign new_entry = {nxt_conf, nxt_cand, nxt_reps, nxt_dwell};

  khf_update #(
    .DWELL_WIDTH (DWELL_WIDTH)
  ) u_update (
    .cfg_i          (cfg),
    .conf_i         (cur_conf),
    .cand_i         (cur_cand),
    .reps_i         (cur_reps),
    .dwell_i        (cur_dwell),
    .raw_class_i    (s1_raw_q),
    .confidence_i   (s1_conf_q),
    .change_point_i (s1_cp_q),
    .conf_o         (nxt_conf),
    .cand_o         (nxt_cand),
    .reps_o         (nxt_reps),
    .dwell_o        (nxt_dwell),
    .res_o          (res)
  );

  // stage valids
  logic s1_valid_d;
  logic out_valid_d;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = in_acc;
    end else if (in_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  khf_pkg::result_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign filtered_class_o    = out_q.filtered_class;
  assign class_group_o       = out_q.class_group;
  assign overrode_o          = out_q.overrode;
  assign repeats_remaining_o = out_q.repeats_remaining;
  assign dwell_count_o       = out_q.dwell_count;
  assign transition_o        = out_q.transition;
  assign previous_class_o    = out_q.previous_class;

endmodule

`default_nettype wire

/* rtl/core/khf_chk.sv */
// port-level checker of the keyed class hysteresis filter, bound to the top level
`default_nettype none

module khf_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [khf_pkg::CLASS_W-1:0]     filtered_class_o,
  input wire logic [khf_pkg::GROUP_W-1:0]     class_group_o,
  input wire logic                            overrode_o,
  input wire logic [khf_pkg::REP_W-1:0]       repeats_remaining_o,
  input wire logic [khf_pkg::DWELL_OUT_W-1:0] dwell_count_o,
  input wire logic                            transition_o,
  input wire logic [khf_pkg::CLASS_W-1:0]     previous_class_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_class_o)
      && $stable(dwell_count_o) && $stable(previous_class_o)
      && $stable(repeats_remaining_o) && $stable(class_group_o)
      && $stable(overrode_o) && $stable(transition_o))
    else $error("stalled result beat changed");

  a_transition: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transition_o |->
      previous_class_o != khf_pkg::CLASS_UNDEF && filtered_class_o != previous_class_o)
    else $error("transition flagged without a change from a defined class");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> filtered_class_o <= khf_pkg::MAX_CLASS
      && previous_class_o <= khf_pkg::MAX_CLASS)
    else $error("class code out of range");

  a_undef_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && filtered_class_o == khf_pkg::CLASS_UNDEF |->
      class_group_o == khf_pkg::GRP_UNCLEAR)
    else $error("undefined class not in unclear group");

endmodule

bind keyed_class_hysteresis_filter khf_chk u_khf_chk (.*);

`default_nettype wire
